// File: hw/rtl/mlwf_pkg.sv
// Shared constants, types and control structs for the memory LCD line-write framer.
// No dependencies. The controller, the datapath and the top level use it.
`timescale 1ns / 1ps

package mlwf_pkg;

    // Panel geometry.
    localparam int ROW_BYTES   = 18;
    localparam int ROWS        = 168;
    localparam int STORE_DEPTH = ROWS * ROW_BYTES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Field widths.
    localparam int ROW_W  = 8;
    localparam int IDX_W  = 5;
    localparam int BYTE_W = 8;

    // Input word packing, lowest bits first.
    localparam int S_ROW_LSB  = 0;
    localparam int S_IDX_LSB  = S_ROW_LSB + ROW_W;
    localparam int S_PIX_LSB  = S_IDX_LSB + IDX_W;
    localparam int S_USED_W   = S_PIX_LSB + BYTE_W;
    localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = BYTE_W;
    localparam int M_TUSER_W  = 2;

    // Stream constants.
    localparam logic [BYTE_W-1:0] CMD_WRITE  = 8'h01;
    localparam logic [BYTE_W-1:0] DUMMY_BYTE = 8'h00;

    // Function codes carried on s_tuser.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_ADDR,
        ST_DATA,
        ST_DUMMY,
        ST_FINAL,
        ST_ERR
    } state_t;

    typedef enum logic [2:0] {
        SEL_CMD,
        SEL_ROW,
        SEL_DATA,
        SEL_DUMMY,
        SEL_ERR
    } out_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load_item;
        logic     mem_write;
        logic     out_load;
        out_sel_t out_sel;
        logic     out_last;
        logic     out_done;
        logic     cnt_adv;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic cnt_last;
        logic row_ok;
        logic idx_ok;
        logic final_row;
    } status_t;

endpackage

// File: hw/rtl/memory_lcd_line_write_framer_top.sv
// Top level of the memory LCD line-write framer.
// Depends on mlwf_pkg, mlwf_ctrl and mlwf_dp.
//
// Input channel (s_): each word is either a frame store write (s_tuser = 0), which
// stores pixel_byte at row_number/byte_index, or a row flush (s_tuser = 1), which
// streams the row to the panel; s_tlast marks the flush that ends the write burst.
// Output channel (m_): one panel stream byte per word, with m_tlast on the last
// byte caused by an input word, m_tuser[0] on the burst-closing dummy byte and
// m_tuser[1] on the single error word of a flush with a row outside 1..168.
// A write produces no output. A good flush emits 20 to 22 bytes, one per cycle
// while the receiver takes them, and holds the input until its last byte is loaded;
// once accepted, the state register leaves IDLE and the first byte then enters the
// output register when free. The single output register sets the rate; data bytes
// come from the frame store read port. The next word is accepted while the last byte waits.
// Reset (aresetn low, synchronous) closes any open burst and empties the output
// register; the frame store keeps no reset state and must be written before use.
// When the receiver stalls, the sequence halts with the pending byte held stable.
`timescale 1ns / 1ps

module memory_lcd_line_write_framer_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata: row_number[7:0], byte_index[12:8], pixel_byte[20:13], zero fill above.
    input  logic [mlwf_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: func.
    input  logic                               s_tuser,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: stream_byte[7:0].
    output logic [mlwf_pkg::M_TDATA_W-1:0]     m_tdata,
    // m_tuser: burst_done[0], row_error[1].
    output logic [mlwf_pkg::M_TUSER_W-1:0]     m_tuser,
    output logic                               m_tlast
);

    mlwf_pkg::cmd_t    cmd;
    mlwf_pkg::status_t status;

    mlwf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_func   (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mlwf_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_row   (s_tdata[mlwf_pkg::S_IDX_LSB-1:mlwf_pkg::S_ROW_LSB]),
        .in_idx   (s_tdata[mlwf_pkg::S_PIX_LSB-1:mlwf_pkg::S_IDX_LSB]),
        .in_pix   (s_tdata[mlwf_pkg::S_USED_W-1:mlwf_pkg::S_PIX_LSB]),
        .in_final (s_tlast),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// File: hw/rtl/mlwf_ctrl.sv
// Controller state machine of the line-write framer: accepts writes and sequences each row flush.
// Depends on mlwf_pkg; drives the datapath through mlwf_pkg::cmd_t.
`timescale 1ns / 1ps

module mlwf_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_func,
    output logic             s_tready,
    input  mlwf_pkg::status_t status,
    output mlwf_pkg::cmd_t    cmd
);

    mlwf_pkg::state_t state_reg;
    mlwf_pkg::state_t state_next;
    logic             burst_open_reg;
    logic             burst_open_next;
    logic             accept;

    assign s_tready = (state_reg == mlwf_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= mlwf_pkg::ST_IDLE;
            burst_open_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            burst_open_reg <= burst_open_next;
        end
    end

    // Next state and burst tracking.
    always_comb begin
        state_next      = state_reg;
        burst_open_next = burst_open_reg;
        case (state_reg)
            mlwf_pkg::ST_IDLE: begin
                if (accept && s_func == mlwf_pkg::FUNC_FLUSH) begin
                    if (!status.row_ok) begin
                        state_next      = mlwf_pkg::ST_ERR;
                        burst_open_next = 1'b0;
                    end else begin
                        state_next      = burst_open_reg ? mlwf_pkg::ST_ADDR
                                                         : mlwf_pkg::ST_CMD;
                        burst_open_next = 1'b1;
                    end
                end
            end
            mlwf_pkg::ST_CMD: begin
                if (status.out_free) state_next = mlwf_pkg::ST_ADDR;
            end
            mlwf_pkg::ST_ADDR: begin
                if (status.out_free) state_next = mlwf_pkg::ST_DATA;
            end
            mlwf_pkg::ST_DATA: begin
                if (status.out_free && status.cnt_last) state_next = mlwf_pkg::ST_DUMMY;
            end
            mlwf_pkg::ST_DUMMY: begin
                if (status.out_free) begin
                    state_next = status.final_row ? mlwf_pkg::ST_FINAL : mlwf_pkg::ST_IDLE;
                end
            end
            mlwf_pkg::ST_FINAL: begin
                if (status.out_free) begin
                    state_next      = mlwf_pkg::ST_IDLE;
                    burst_open_next = 1'b0;
                end
            end
            mlwf_pkg::ST_ERR: begin
                if (status.out_free) state_next = mlwf_pkg::ST_IDLE;
            end
            default: begin
                state_next = mlwf_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath commands.
    always_comb begin
        cmd           = '0;
        cmd.out_sel   = mlwf_pkg::SEL_DUMMY;
        cmd.load_item = accept;
        case (state_reg)
            mlwf_pkg::ST_IDLE: begin
                cmd.mem_write = accept && (s_func == mlwf_pkg::FUNC_WRITE)
                                && status.row_ok && status.idx_ok;
            end
            mlwf_pkg::ST_CMD: begin
                cmd.out_load = status.out_free;
                cmd.out_sel  = mlwf_pkg::SEL_CMD;
            end
            mlwf_pkg::ST_ADDR: begin
                cmd.out_load = status.out_free;
                cmd.out_sel  = mlwf_pkg::SEL_ROW;
            end
            mlwf_pkg::ST_DATA: begin
                cmd.out_load = status.out_free;
                cmd.out_sel  = mlwf_pkg::SEL_DATA;
                cmd.cnt_adv  = status.out_free;
            end
            mlwf_pkg::ST_DUMMY: begin
                cmd.out_load = status.out_free;
                cmd.out_sel  = mlwf_pkg::SEL_DUMMY;
                cmd.out_last = !status.final_row;
            end
            mlwf_pkg::ST_FINAL: begin
                cmd.out_load = status.out_free;
                cmd.out_sel  = mlwf_pkg::SEL_DUMMY;
                cmd.out_last = 1'b1;
                cmd.out_done = 1'b1;
            end
            mlwf_pkg::ST_ERR: begin
                cmd.out_load = status.out_free;
                cmd.out_sel  = mlwf_pkg::SEL_ERR;
                cmd.out_last = 1'b1;
            end
            default: begin
                cmd.out_load = 1'b0;
            end
        endcase
    end

endmodule

// File: hw/rtl/mlwf_dp.sv
// Datapath of the line-write framer: frame store, row byte counter, output register.
// Depends on mlwf_pkg; takes commands from mlwf_ctrl and returns status.
`timescale 1ns / 1ps

module mlwf_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [mlwf_pkg::ROW_W-1:0]          in_row,
    input  logic [mlwf_pkg::IDX_W-1:0]          in_idx,
    input  logic [mlwf_pkg::BYTE_W-1:0]         in_pix,
    input  logic                                in_final,
    input  mlwf_pkg::cmd_t                      cmd,
    output mlwf_pkg::status_t                   status,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mlwf_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    output logic [mlwf_pkg::M_TUSER_W-1:0]      m_tuser
);

    logic [mlwf_pkg::BYTE_W-1:0] mem [mlwf_pkg::STORE_DEPTH];

    logic [mlwf_pkg::ADDR_W-1:0] in_base;
    logic [mlwf_pkg::ADDR_W-1:0] wr_addr;
    logic [mlwf_pkg::ADDR_W-1:0] rd_addr;
    logic [mlwf_pkg::IDX_W-1:0]  rd_idx;
    logic [mlwf_pkg::BYTE_W-1:0] rd_data_reg;

    logic [mlwf_pkg::ADDR_W-1:0] base_reg;
    logic [mlwf_pkg::ROW_W-1:0]  row_reg;
    logic                        final_reg;
    logic [mlwf_pkg::IDX_W-1:0]  cnt_reg;
    logic [mlwf_pkg::IDX_W-1:0]  cnt_next;

    logic                           m_tvalid_reg;
    logic [mlwf_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [mlwf_pkg::M_TDATA_W-1:0] m_tdata_next;
    logic                           m_tlast_reg;
    logic [mlwf_pkg::M_TUSER_W-1:0] m_tuser_reg;

    // Row base in the packed store; the product by a constant reduces to shifts and adds.
    assign in_base = mlwf_pkg::ADDR_W'(in_row - mlwf_pkg::ROW_W'(1))
                     * mlwf_pkg::ADDR_W'(mlwf_pkg::ROW_BYTES);
    assign wr_addr = in_base + mlwf_pkg::ADDR_W'(in_idx);

    assign status.row_ok    = (in_row >= mlwf_pkg::ROW_W'(1))
                              && (in_row <= mlwf_pkg::ROW_W'(mlwf_pkg::ROWS));
    assign status.idx_ok    = (in_idx < mlwf_pkg::IDX_W'(mlwf_pkg::ROW_BYTES));
    assign status.final_row = final_reg;
    assign status.cnt_last  = (cnt_reg == mlwf_pkg::IDX_W'(mlwf_pkg::ROW_BYTES - 1));
    assign status.out_free  = !m_tvalid_reg || m_tready;

    // The read runs one byte ahead: when a data byte goes out, the next one is fetched.
    assign cnt_next = cmd.load_item ? '0
                    : (cmd.cnt_adv ? cnt_reg + mlwf_pkg::IDX_W'(1) : cnt_reg);
    assign rd_idx   = cmd.cnt_adv ? cnt_reg + mlwf_pkg::IDX_W'(1) : cnt_reg;
    assign rd_addr  = base_reg + mlwf_pkg::ADDR_W'(rd_idx);

    always_ff @(posedge aclk) begin
        if (cmd.mem_write) begin
            mem[wr_addr] <= in_pix;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            base_reg  <= in_base;
            row_reg   <= in_row;
            final_reg <= in_final;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_comb begin
        case (cmd.out_sel)
            mlwf_pkg::SEL_CMD:   m_tdata_next = mlwf_pkg::CMD_WRITE;
            mlwf_pkg::SEL_ROW:   m_tdata_next = row_reg;
            mlwf_pkg::SEL_DATA:  m_tdata_next = rd_data_reg;
            mlwf_pkg::SEL_DUMMY: m_tdata_next = mlwf_pkg::DUMMY_BYTE;
            mlwf_pkg::SEL_ERR:   m_tdata_next = mlwf_pkg::DUMMY_BYTE;
            default:             m_tdata_next = mlwf_pkg::DUMMY_BYTE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= m_tdata_next;
            m_tlast_reg <= cmd.out_last;
            m_tuser_reg <= {cmd.out_sel == mlwf_pkg::SEL_ERR, cmd.out_done};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: verif/mlwf_stream_checker.sv
// Stream checker for the memory LCD line-write framer: it models the frame store and the burst
// state, predicts the panel bytes of each accepted input word and compares every output word.
// Depends on mlwf_pkg.
`timescale 1ns / 1ps

module mlwf_stream_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // s_tdata: row_number[7:0], byte_index[12:8], pixel_byte[20:13], zero fill above.
    input  logic [mlwf_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: func.
    input  logic                           s_tuser,
    input  logic                           s_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: stream_byte[7:0].
    input  logic [mlwf_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: burst_done[0], row_error[1].
    input  logic [mlwf_pkg::M_TUSER_W-1:0] m_tuser,
    input  logic                           m_tlast,
    output int                             fail_count,
    output int                             words_owed
);
    import mlwf_pkg::*;

    localparam int DONE_BIT = 0;
    localparam int ERR_BIT  = 1;
    localparam logic [BYTE_W-1:0] ERR_BYTE = 8'h00;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              done;
        logic              err;
        logic              last;
    } panel_word_t;

    logic [BYTE_W-1:0] frame_copy [0:STORE_DEPTH-1];
    logic              burst_live = 1'b0;
    panel_word_t       panel_due [$];
    int                mismatches = 0;
    int                owed_count = 0;

    assign fail_count = mismatches;
    assign words_owed = owed_count;

    task automatic report_mismatch(input string what);
        if (mismatches < 40)
            $display("[%0t] MISMATCH %s", $time, what);
        mismatches++;
    endtask

    task automatic predict_panel_bytes(input logic func, input logic [ROW_W-1:0] row,
                                       input logic [IDX_W-1:0] idx,
                                       input logic [BYTE_W-1:0] pix, input logic fin);
        logic [BYTE_W-1:0] seq [$];
        logic              row_ok;
        int                base;
        row_ok = (row >= 1) && (row <= ROWS);
        base = (int'(row) - 1) * ROW_BYTES;
        if (func == FUNC_WRITE) begin
            if (row_ok && idx < ROW_BYTES)
                frame_copy[base + int'(idx)] = pix;
        end else if (!row_ok) begin
            // A bad row aborts the burst with one error word; final_row plays no part.
            burst_live = 1'b0;
            panel_due.push_back('{data: ERR_BYTE, done: 1'b0, err: 1'b1, last: 1'b1});
        end else begin
            if (!burst_live)
                seq.push_back(CMD_WRITE);
            seq.push_back(row);
            for (int i = 0; i < ROW_BYTES; i++)
                seq.push_back(frame_copy[base + i]);
            seq.push_back(DUMMY_BYTE);
            if (fin)
                seq.push_back(DUMMY_BYTE);
            burst_live = !fin;
            foreach (seq[k])
                panel_due.push_back('{data: seq[k], done: fin && (k == seq.size() - 1),
                                      err: 1'b0, last: (k == seq.size() - 1)});
        end
    endtask

    always @(posedge aclk) begin : watch
        panel_word_t want;
        if (!aresetn) begin
            panel_due.delete();
            burst_live = 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                predict_panel_bytes(s_tuser, s_tdata[S_ROW_LSB +: ROW_W],
                                    s_tdata[S_IDX_LSB +: IDX_W],
                                    s_tdata[S_PIX_LSB +: BYTE_W], s_tlast);
            if (m_tvalid && m_tready) begin
                if (panel_due.size() == 0) begin
                    report_mismatch($sformatf("word %h with no byte expected", m_tdata));
                end else begin
                    want = panel_due.pop_front();
                    if (m_tdata !== want.data)
                        report_mismatch($sformatf("stream byte %h, expected %h",
                                                  m_tdata, want.data));
                    if (m_tuser[DONE_BIT] !== want.done)
                        report_mismatch($sformatf("burst_done %b, expected %b",
                                                  m_tuser[DONE_BIT], want.done));
                    if (m_tuser[ERR_BIT] !== want.err)
                        report_mismatch($sformatf("row_error %b, expected %b",
                                                  m_tuser[ERR_BIT], want.err));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("tlast %b, expected %b", m_tlast, want.last));
                end
            end
        end
        // Updated late so the stimulus side always sees last cycle's count.
        owed_count <= panel_due.size();
    end

endmodule

// File: verif/tb.sv
// Testbench top for the memory LCD line-write framer: drives frame store writes and row
// flushes with random gaps and receiver stalls, and gives the verdict.
// Depends on mlwf_pkg, memory_lcd_line_write_framer_top and mlwf_stream_checker.
`timescale 1ns / 1ps

module tb;
    import mlwf_pkg::*;

    localparam int RANDOM_ITEMS = 120;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;
    int                   fail_count;
    int                   words_owed;

    // Which store bytes hold data; only rows written in full may be flushed.
    bit [ROW_BYTES-1:0]   row_seen [1:ROWS];
    int                   flushable_rows [$];
    bit                   send_quiet = 1'b0;
    bit                   sink_quiet = 1'b0;

    memory_lcd_line_write_framer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    mlwf_stream_checker stream_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .words_owed (words_owed)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(3, 1);
        else if (r < 96)
            return $urandom_range(12, 4);
        else
            return $urandom_range(50, 20);
    endfunction

    task automatic send_word(input logic func, input logic [ROW_W-1:0] row,
                             input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] pix,
                             input logic fin);
        int                   gap;
        logic [S_TDATA_W-1:0] word;
        bit                   was_full;
        gap = send_quiet ? 0 : pick_gap();
        word = '0;
        word[S_ROW_LSB +: ROW_W]  = row;
        word[S_IDX_LSB +: IDX_W]  = idx;
        word[S_PIX_LSB +: BYTE_W] = pix;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= func;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        if (func == FUNC_WRITE && row >= 1 && row <= ROWS && idx < ROW_BYTES) begin
            was_full = &row_seen[row];
            row_seen[row][idx] = 1'b1;
            if (!was_full && &row_seen[row])
                flushable_rows.push_back(row);
        end
    endtask

    task automatic fill_row_bytes(input int row);
        logic [BYTE_W-1:0] pix;
        for (int i = 0; i < ROW_BYTES; i++) begin
            pix = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom_range(255));
            send_word(FUNC_WRITE, 8'(row), 5'(i), pix, 1'b0);
        end
    endtask

    function automatic logic [ROW_W-1:0] pick_bad_row();
        if ($urandom_range(3) == 0)
            return 8'd0;
        return 8'($urandom_range(255, ROWS + 1));
    endfunction

    // Receiver: takes words for a while, then stalls for a random stretch.
    initial begin : sink
        int len;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if ($urandom_range(39) == 0)
                sink_quiet = !sink_quiet;
            if (sink_quiet || $urandom_range(99) < 60) begin
                m_tready <= 1'b1;
            end else begin
                len = pick_gap();
                if (len == 0)
                    len = 1;
                m_tready <= 1'b0;
                repeat (len - 1) @(posedge aclk);
            end
        end
    end

    initial begin : limit
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int                counted;
        int                pick;
        int                filling;
        int                fill_pos;
        logic [ROW_W-1:0]  row;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= FUNC_WRITE;
        s_tlast  <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: the first and the last row hold data before anything is flushed.
        fill_row_bytes(1);
        fill_row_bytes(ROWS);
        send_word(FUNC_WRITE, 8'd0, 5'd0, 8'hFF, 1'b1);
        send_word(FUNC_WRITE, 8'(ROWS + 1), 5'd3, 8'h5A, 1'b0);
        send_word(FUNC_WRITE, 8'd255, 5'd31, 8'hFF, 1'b0);
        send_word(FUNC_WRITE, 8'd1, 5'(ROW_BYTES), 8'hC3, 1'b0);
        send_word(FUNC_WRITE, 8'd1, 5'd31, 8'h3C, 1'b0);
        send_word(FUNC_FLUSH, 8'd1, 5'd0, 8'h00, 1'b0);
        send_word(FUNC_FLUSH, 8'(ROWS), 5'd0, 8'h00, 1'b1);
        send_word(FUNC_FLUSH, 8'd1, 5'd0, 8'h00, 1'b1);
        send_word(FUNC_FLUSH, 8'd0, 5'd0, 8'h00, 1'b0);
        send_word(FUNC_FLUSH, 8'd1, 5'd0, 8'h00, 1'b0);
        // A bad row inside an open burst aborts it; the next flush starts a new burst.
        send_word(FUNC_FLUSH, 8'd255, 5'd31, 8'hFF, 1'b1);
        send_word(FUNC_FLUSH, 8'(ROWS), 5'd0, 8'h00, 1'b0);
        send_word(FUNC_FLUSH, 8'(ROWS + 1), 5'd0, 8'h00, 1'b0);
        send_word(FUNC_WRITE, 8'd1, 5'(ROW_BYTES - 1), 8'hA5, 1'b0);
        send_word(FUNC_FLUSH, 8'd1, 5'd0, 8'h00, 1'b1);

        // Random part: mostly rows being filled and flushed in bursts of a few rows.
        do filling = $urandom_range(ROWS, 1); while (&row_seen[filling]);
        fill_pos = 0;
        counted  = 0;
        while (counted < RANDOM_ITEMS) begin
            if ($urandom_range(24) == 0)
                send_quiet = !send_quiet;
            pick = $urandom_range(99);
            if (pick < 25) begin
                send_word(FUNC_WRITE, 8'(filling), 5'(fill_pos), 8'($urandom_range(255)),
                          1'($urandom_range(1)));
                fill_pos++;
                if (fill_pos == ROW_BYTES) begin
                    fill_pos = 0;
                    do filling = $urandom_range(ROWS, 1); while (&row_seen[filling]);
                end
                counted++;
            end else if (pick < 45) begin
                if ($urandom_range(1) == 0)
                    row = 8'(flushable_rows[$urandom_range(flushable_rows.size() - 1)]);
                else
                    row = 8'($urandom_range(ROWS, 1));
                send_word(FUNC_WRITE, row, 5'($urandom_range(ROW_BYTES - 1)),
                          8'($urandom_range(255)), 1'($urandom_range(1)));
                counted++;
            end else if (pick < 85) begin
                row = 8'(flushable_rows[$urandom_range(flushable_rows.size() - 1)]);
                send_word(FUNC_FLUSH, row, 5'($urandom_range(31)), 8'($urandom_range(255)),
                          $urandom_range(2) == 0);
                counted++;
            end else if (pick < 92) begin
                send_word(FUNC_FLUSH, pick_bad_row(), 5'($urandom_range(31)),
                          8'($urandom_range(255)), 1'($urandom_range(1)));
                counted++;
            end else if ($urandom_range(1) == 0) begin
                // Out-of-range writes are dropped by the block and do not count.
                send_word(FUNC_WRITE, pick_bad_row(), 5'($urandom_range(31)),
                          8'($urandom_range(255)), 1'($urandom_range(1)));
            end else begin
                send_word(FUNC_WRITE, 8'($urandom_range(ROWS, 1)),
                          5'($urandom_range(31, ROW_BYTES)), 8'($urandom_range(255)),
                          1'($urandom_range(1)));
            end
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (words_owed != 0)
            @(posedge aclk);
        repeat (30) @(posedge aclk);
        @(negedge aclk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
